@@ rtl/ilac_pkg.sv @@
// ----------------------------------------------------------------------------
// ilac_pkg: shared types and constants for the integer literal check
// Parse phases, the parser's control state and the load width codes.
// ----------------------------------------------------------------------------
package ilac_pkg;

	localparam int unsigned VALUE_BITS_DEF = 64;

	// One-hot parse phases
	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_LEAD   = 8'b0000_0010,
		PH_ZERO   = 8'b0000_0100,
		PH_DEC    = 8'b0000_1000,
		PH_HEX    = 8'b0001_0000,
		PH_FRAC   = 8'b0010_0000,
		PH_SUFFIX = 8'b0100_0000,
		PH_BAD    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   digit_seen;
	} ctl_t;

	// Load width codes carried in s_tuser
	localparam logic [1:0] LOAD_2W = 2'd0;
	localparam logic [1:0] LOAD_3W = 2'd1;
	localparam logic [1:0] LOAD_4W = 2'd2;

	localparam ctl_t CTL_RESET = '{phase: PH_START, digit_seen: 1'b0};

endpackage

@@ rtl/ilac_parse.sv @@
// ----------------------------------------------------------------------------
// ilac_parse: next-state logic of the literal parser
// Classifies one character and steps phase, accumulator and digit flag.
// ----------------------------------------------------------------------------
module ilac_parse #(
	parameter int unsigned VALUE_BITS = ilac_pkg::VALUE_BITS_DEF
) (
	input  logic [7:0]            character,
	input  ilac_pkg::ctl_t        ctl_cur,
	input  logic [VALUE_BITS-1:0] acc_cur,
	output ilac_pkg::ctl_t        ctl_nxt,
	output logic [VALUE_BITS-1:0] acc_nxt
);

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UL   = 8'h4C;
	localparam logic [7:0] CH_UU   = 8'h55;
	localparam logic [7:0] CH_LL   = 8'h6C;
	localparam logic [7:0] CH_LU   = 8'h75;
	localparam logic [7:0] CH_UX   = 8'h58;
	localparam logic [7:0] CH_LX   = 8'h78;

	logic                  is_dec;
	logic                  is_hex_lo;
	logic                  is_hex_up;
	logic                  is_sfx;
	logic [3:0]            hex_val;
	logic [VALUE_BITS-1:0] dec_acc;
	logic [VALUE_BITS-1:0] hex_acc;
	ilac_pkg::phase_t      after_dig;

	assign is_dec    = (character >= CH_0) && (character <= CH_9);
	assign is_hex_lo = (character >= CH_LA) && (character <= CH_LF);
	assign is_hex_up = (character >= CH_UA) && (character <= CH_UF);
	assign is_sfx    = (character == CH_UL) || (character == CH_UU) ||
	                   (character == CH_LL) || (character == CH_LU);

	always_comb begin
		hex_val = 4'(character - CH_0);
		if (is_hex_lo) begin
			hex_val = 4'(character - CH_LA + 8'd10);
		end else if (is_hex_up) begin
			hex_val = 4'(character - CH_UA + 8'd10);
		end
	end

	// acc * 10 + digit as two shifted copies and the digit, wrapping
	assign dec_acc = (acc_cur << 3) + (acc_cur << 1) +
	                 VALUE_BITS'(character - CH_0);
	assign hex_acc = (acc_cur << 4) | VALUE_BITS'(hex_val);

	always_comb begin
		if (character == CH_DOT) begin
			after_dig = ilac_pkg::PH_FRAC;
		end else if (is_sfx) begin
			after_dig = ilac_pkg::PH_SUFFIX;
		end else begin
			after_dig = ilac_pkg::PH_BAD;
		end
	end

	always_comb begin
		ilac_pkg::phase_t eff;
		eff     = ctl_cur.phase;
		ctl_nxt = ctl_cur;
		acc_nxt = acc_cur;
		// A leading sign is optional; a zero not followed by x continues as decimal
		if (eff == ilac_pkg::PH_START && character != CH_PLUS) begin
			eff = ilac_pkg::PH_LEAD;
		end
		if (eff == ilac_pkg::PH_ZERO && character != CH_UX && character != CH_LX) begin
			eff = ilac_pkg::PH_DEC;
		end
		case (eff)
			ilac_pkg::PH_START: begin
				ctl_nxt.phase = ilac_pkg::PH_LEAD;
			end
			ilac_pkg::PH_LEAD: begin
				if (character == CH_0) begin
					acc_nxt            = '0;
					ctl_nxt.digit_seen = 1'b1;
					ctl_nxt.phase      = ilac_pkg::PH_ZERO;
				end else if (is_dec) begin
					acc_nxt            = dec_acc;
					ctl_nxt.digit_seen = 1'b1;
					ctl_nxt.phase      = ilac_pkg::PH_DEC;
				end else begin
					ctl_nxt.phase = ilac_pkg::PH_BAD;
				end
			end
			ilac_pkg::PH_ZERO: begin
				acc_nxt            = '0;
				ctl_nxt.digit_seen = 1'b0;
				ctl_nxt.phase      = ilac_pkg::PH_HEX;
			end
			ilac_pkg::PH_DEC: begin
				if (is_dec) begin
					acc_nxt            = dec_acc;
					ctl_nxt.digit_seen = 1'b1;
					ctl_nxt.phase      = ilac_pkg::PH_DEC;
				end else begin
					ctl_nxt.phase = after_dig;
				end
			end
			ilac_pkg::PH_HEX: begin
				if (is_dec || is_hex_lo || is_hex_up) begin
					acc_nxt            = hex_acc;
					ctl_nxt.digit_seen = 1'b1;
					ctl_nxt.phase      = ilac_pkg::PH_HEX;
				end else begin
					ctl_nxt.phase = ctl_cur.digit_seen ? after_dig : ilac_pkg::PH_BAD;
				end
			end
			ilac_pkg::PH_FRAC: begin
				if (character == CH_0) begin
					ctl_nxt.phase = ilac_pkg::PH_FRAC;
				end else if (is_sfx) begin
					ctl_nxt.phase = ilac_pkg::PH_SUFFIX;
				end else begin
					ctl_nxt.phase = ilac_pkg::PH_BAD;
				end
			end
			ilac_pkg::PH_SUFFIX: begin
				ctl_nxt.phase = is_sfx ? ilac_pkg::PH_SUFFIX : ilac_pkg::PH_BAD;
			end
			default: begin
				ctl_nxt.phase = ilac_pkg::PH_BAD;
			end
		endcase
	end

endmodule

@@ rtl/integer_literal_alignment_check.sv @@
// ----------------------------------------------------------------------------
// integer_literal_alignment_check: streaming integer literal parser
// Parses one literal per frame and flags values that break load alignment.
// ----------------------------------------------------------------------------
// The literal arrives one character per word on the slave side, the final
// character marked by s_tlast, with the load width code in s_tuser on that
// word. The block takes one word every cycle while s_tready is high: the
// per-character step (class decode plus a shift-add of the accumulator) is
// combinational in ilac_parse, so throughput is then one character per cycle
// with no gaps between literals. A result enters the result register if it
// is free or being taken, else the skid register; this two-entry stage keeps
// s_tready high through a master-side stall until a second
// finished result has to wait behind the first; only then does s_tready drop,
// and it rises again the cycle after the master side takes a word. An
// optional '+', decimal or 0x/0X hex digits, a dot followed only by zeros, and
// u/U/l/L suffixes are accepted; anything else marks the literal invalid,
// which forces the value and the misaligned flag to zero. The value wraps
// modulo 2^VALUE_BITS. Alignment is 8 bytes for two-word loads and 16 bytes
// for three- and four-word loads; the unused load code never flags.
// ----------------------------------------------------------------------------
module integer_literal_alignment_check #(
	parameter int unsigned VALUE_BITS = ilac_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // last_char
	input  logic [1:0]  s_tuser,   // [1:0] load_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] literal_value
	output logic [1:0]  m_tuser    // [0] literal_valid, [1] misaligned
);

	ilac_pkg::ctl_t        ctl_q;
	logic [VALUE_BITS-1:0] acc_q;
	ilac_pkg::ctl_t        ctl_nxt;
	logic [VALUE_BITS-1:0] acc_nxt;

	logic        accept;
	logic        push;
	logic        pop;
	logic        res_valid;
	logic [63:0] res_value;
	logic        res_misal;

	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_flags_q;
	logic        skid_valid_q;
	logic [63:0] skid_value_q;
	logic [1:0]  skid_flags_q;

	ilac_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.character(s_tdata),
		.ctl_cur  (ctl_q),
		.acc_cur  (acc_q),
		.ctl_nxt  (ctl_nxt),
		.acc_nxt  (acc_nxt)
	);

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && s_tlast;
	assign pop      = out_valid_q && m_tready;

	// Result of the literal ending with this character
	assign res_valid = ctl_nxt.digit_seen &&
	                   ctl_nxt.phase != ilac_pkg::PH_START &&
	                   ctl_nxt.phase != ilac_pkg::PH_LEAD &&
	                   ctl_nxt.phase != ilac_pkg::PH_BAD;
	assign res_value = res_valid ? 64'(acc_nxt) : 64'd0;

	always_comb begin
		case (s_tuser)
			ilac_pkg::LOAD_2W: res_misal = res_valid && (|res_value[2:0]);
			ilac_pkg::LOAD_3W,
			ilac_pkg::LOAD_4W: res_misal = res_valid && (|res_value[3:0]);
			default:           res_misal = 1'b0;
		endcase
	end

	// Parser state: advance on each word, return to start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= ilac_pkg::CTL_RESET;
			acc_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				ctl_q <= ilac_pkg::CTL_RESET;
				acc_q <= '0;
			end else begin
				ctl_q <= ctl_nxt;
				acc_q <= acc_nxt;
			end
		end
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_value_q <= skid_value_q;
				out_flags_q <= skid_flags_q;
			end else if (push) begin
				out_value_q <= res_value;
				out_flags_q <= {res_misal, res_valid};
			end
		end else if (push) begin
			skid_value_q <= res_value;
			skid_flags_q <= {res_misal, res_valid};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_flags_q;

`ifndef SYNTHESIS
	// The skid entry is only ever filled behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	// Misaligned is only reported for a valid literal
	a_misal_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("misaligned flagged on an invalid literal");

	// An invalid literal reports a zero value
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
		else $error("invalid literal with nonzero value");

	// The parser restarts after each last character
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> ctl_q.phase == ilac_pkg::PH_START && !ctl_q.digit_seen)
		else $error("parser did not restart after the last character");

	// A result accepted into an empty output stage shows up next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !out_valid_q |=> m_tvalid)
		else $error("result of a last character was lost");
`endif

endmodule

@@ tb/sv/integer_literal_alignment_check_tb.sv @@
// ----------------------------------------------------------------------------
// integer_literal_alignment_check_tb: self-checking bench for the literal check
// Streams literal text one character per word, predicts each result word from
// its own parser model and compares it field by field on the master side.
// ----------------------------------------------------------------------------
module integer_literal_alignment_check_tb;

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic        misaligned;
	} literal_result_t;

	// The load code the package leaves unnamed: no alignment applies
	localparam logic [1:0] LOAD_NONE = 2'd3;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_REPORTS      = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] character
	logic        s_tlast;   // last_char
	logic [1:0]  s_tuser;   // [1:0] load_kind
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [63:0] literal_value
	logic [1:0]  m_tuser;   // [0] literal_valid, [1] misaligned

	// Parser model state, kept in step with every accepted word
	ilac_pkg::phase_t model_phase = ilac_pkg::PH_START;
	logic [63:0]      model_acc   = 64'd0;
	logic             model_digit = 1'b0;

	literal_result_t expected_results[$];
	char_t           lit_buf[$];

	int sent_words     = 0;
	int mismatch_count = 0;
	bit idle_on        = 1'b0;
	int hold_req       = 0;

	integer_literal_alignment_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic bit is_dec_char(char_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_suffix_char(char_t c);
		return c == "u" || c == "U" || c == "l" || c == "L";
	endfunction

	// What may follow the digits of a literal that has digits
	function automatic ilac_pkg::phase_t after_digits_phase(char_t c);
		if (c == ".")
			return ilac_pkg::PH_FRAC;
		if (is_suffix_char(c))
			return ilac_pkg::PH_SUFFIX;
		return ilac_pkg::PH_BAD;
	endfunction

	// Advance the phase by one character; update the accumulator as a side effect
	function automatic ilac_pkg::phase_t advance_phase(ilac_pkg::phase_t ph, char_t c);
		logic [3:0] nib;
		// A leading '+' is optional: without it, handle the character as a lead
		if (ph == ilac_pkg::PH_START) begin
			if (c == "+")
				return ilac_pkg::PH_LEAD;
			ph = ilac_pkg::PH_LEAD;
		end
		// After a first zero, x/X opens hex; anything else continues as decimal
		if (ph == ilac_pkg::PH_ZERO) begin
			if (c == "x" || c == "X") begin
				model_acc   = 64'd0;
				model_digit = 1'b0;
				return ilac_pkg::PH_HEX;
			end
			ph = ilac_pkg::PH_DEC;
		end
		case (ph)
			ilac_pkg::PH_LEAD: begin
				if (c == "0") begin
					model_acc   = 64'd0;
					model_digit = 1'b1;
					return ilac_pkg::PH_ZERO;
				end
				if (is_dec_char(c)) begin
					model_acc   = model_acc * 64'd10 + {56'd0, c - 8'h30};
					model_digit = 1'b1;
					return ilac_pkg::PH_DEC;
				end
				return ilac_pkg::PH_BAD;
			end
			ilac_pkg::PH_DEC: begin
				if (is_dec_char(c)) begin
					model_acc   = model_acc * 64'd10 + {56'd0, c - 8'h30};
					model_digit = 1'b1;
					return ilac_pkg::PH_DEC;
				end
				return after_digits_phase(c);
			end
			ilac_pkg::PH_HEX: begin
				if (is_dec_char(c))
					nib = 4'(c - 8'h30);
				else if (c >= "a" && c <= "f")
					nib = 4'(c - 8'h61 + 8'd10);
				else if (c >= "A" && c <= "F")
					nib = 4'(c - 8'h41 + 8'd10);
				else
					return model_digit ? after_digits_phase(c) : ilac_pkg::PH_BAD;
				model_acc   = {model_acc[59:0], nib};
				model_digit = 1'b1;
				return ilac_pkg::PH_HEX;
			end
			ilac_pkg::PH_FRAC: begin
				if (c == "0")
					return ilac_pkg::PH_FRAC;
				if (is_suffix_char(c))
					return ilac_pkg::PH_SUFFIX;
				return ilac_pkg::PH_BAD;
			end
			ilac_pkg::PH_SUFFIX:
				return is_suffix_char(c) ? ilac_pkg::PH_SUFFIX : ilac_pkg::PH_BAD;
			default: return ilac_pkg::PH_BAD;
		endcase
	endfunction

	// Step the model with one accepted word; on the last character queue the result
	function automatic void step_parser(char_t c, logic last, logic [1:0] kind);
		literal_result_t r;
		logic [63:0]     amask;
		model_phase = advance_phase(model_phase, c);
		if (last) begin
			r.valid = model_digit && model_phase != ilac_pkg::PH_START &&
				model_phase != ilac_pkg::PH_LEAD && model_phase != ilac_pkg::PH_BAD;
			r.value = r.valid ? model_acc : 64'd0;
			case (kind)
				ilac_pkg::LOAD_2W: amask = 64'd7;
				ilac_pkg::LOAD_3W,
				ilac_pkg::LOAD_4W: amask = 64'd15;
				default:           amask = 64'd0;
			endcase
			r.misaligned = r.valid && ((r.value & amask) != 64'd0);
			expected_results.push_back(r);
			model_phase = ilac_pkg::PH_START;
			model_acc   = 64'd0;
			model_digit = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one word and hold it until accepted; then maybe idle for a burst
	task automatic send_word(input char_t c, input logic last, input logic [1:0] kind);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		step_parser(c, last, kind);
		sent_words++;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// Send the buffered literal as one frame; load code only matters on the last word
	task automatic send_frame(input logic [1:0] kind);
		int i;
		for (i = 0; i < lit_buf.size(); i++) begin
			if (i == lit_buf.size() - 1)
				send_word(lit_buf[i], 1'b1, kind);
			else
				send_word(lit_buf[i], 1'b0, 2'($urandom_range(0, 3)));
		end
		lit_buf.delete();
	endtask

	function automatic void push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			lit_buf.push_back(s[i]);
	endfunction

	task automatic send_text(input string s, input logic [1:0] kind);
		push_text(s);
		send_frame(kind);
	endtask

	// Drop valid and wait until every queued result has come back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// Build one literal: mostly well formed, some broken, some plain noise
	function automatic void make_random_literal();
		int    mode;
		int    n;
		int    i;
		int    d;
		int    pos;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			// noise: arbitrary bytes
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				lit_buf.push_back(char_t'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 3) == 0)
			lit_buf.push_back("+");
		case ($urandom_range(0, 2))
			0: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24)
				                                : $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					lit_buf.push_back(char_t'(8'h30 + $urandom_range(0, 9)));
			end
			1: begin
				lit_buf.push_back("0");
				lit_buf.push_back($urandom_range(0, 1) ? "x" : "X");
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20)
				                                : $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					d = $urandom_range(0, 15);
					if (d < 10)
						lit_buf.push_back(char_t'(8'h30 + d));
					else
						lit_buf.push_back(
							char_t'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 10));
				end
			end
			default: lit_buf.push_back("0");
		endcase
		if ($urandom_range(0, 3) == 0) begin
			lit_buf.push_back(".");
			n = $urandom_range(0, 3);
			for (i = 0; i < n; i++)
				lit_buf.push_back("0");
		end
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++)
				case ($urandom_range(0, 3))
					0:       lit_buf.push_back("u");
					1:       lit_buf.push_back("U");
					2:       lit_buf.push_back("l");
					default: lit_buf.push_back("L");
				endcase
		end
		// broken: corrupt a well-formed literal
		if (mode == 1) begin
			pos = $urandom_range(0, lit_buf.size() - 1);
			case ($urandom_range(0, 2))
				0: lit_buf[pos] = char_t'($urandom_range(0, 255));
				1: lit_buf.insert(pos, $urandom_range(0, 1) ? "e" : "E");
				default: begin
					lit_buf.push_back(".");
					lit_buf.push_back(char_t'(8'h31 + $urandom_range(0, 8)));
				end
			endcase
		end
	endfunction

	task automatic send_random_literal();
		make_random_literal();
		send_frame(2'($urandom_range(0, 3)));
	endtask

	// ------------------------------------------------------------------
	// Receiver side: check every result word, stall in bursts, honor long holds
	// ------------------------------------------------------------------
	initial begin
		int              stall_left;
		int              hold_left;
		int              hold_seen;
		literal_result_t exp_r;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("unexpected result word: valid=%0b value=%h misaligned=%0b",
							m_tuser[0], m_tdata, m_tuser[1]);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tuser[0] !== exp_r.valid || m_tdata !== exp_r.value ||
					    m_tuser[1] !== exp_r.misaligned) begin
						if (mismatch_count < MAX_REPORTS)
							$display("result mismatch: expected valid=%0b value=%h ",
								"misaligned=%0b, got valid=%0b value=%h misaligned=%0b",
								exp_r.valid, exp_r.value, exp_r.misaligned,
								m_tuser[0], m_tdata, m_tuser[1]);
						mismatch_count++;
					end
				end
			end
			// A new hold request starts a long stall counted here in cycles
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Sign, prefix and lead characters, including a lone sign and a bare hex prefix
	task automatic test_sign_and_prefix();
		send_text("+", ilac_pkg::LOAD_2W);
		send_text("0x", ilac_pkg::LOAD_3W);
		send_text("0x.", ilac_pkg::LOAD_4W);
		send_text("++1", ilac_pkg::LOAD_2W);
		send_text("-5", ilac_pkg::LOAD_3W);
		send_text(".", ilac_pkg::LOAD_4W);
	endtask

	// Bare zero and its dot and suffix forms, plus a zero that turns decimal
	task automatic test_zero_forms();
		send_text("0", ilac_pkg::LOAD_2W);
		send_text("0.", ilac_pkg::LOAD_3W);
		send_text("0u", ilac_pkg::LOAD_4W);
		send_text("08", ilac_pkg::LOAD_2W);
		send_text("+0.00L", ilac_pkg::LOAD_3W);
	endtask

	// Fractions, suffixes, exponents and characters after an error
	task automatic test_fraction_and_suffix();
		send_text("12.", ilac_pkg::LOAD_2W);
		send_text("7.000uLlU", ilac_pkg::LOAD_3W);
		send_text("1.5", ilac_pkg::LOAD_4W);
		send_text("1e5", ilac_pkg::LOAD_2W);
		send_text("5u1", ilac_pkg::LOAD_3W);
		send_text("0x1g", ilac_pkg::LOAD_4W);
		send_text("12a34", ilac_pkg::LOAD_2W);
	endtask

	// Value wrap, byte extremes and every load code on one value
	task automatic test_extremes_and_loads();
		send_text("18446744073709551621", ilac_pkg::LOAD_2W);
		send_text("0XfFFFFFFFFFFFFFFFF8", ilac_pkg::LOAD_2W);
		lit_buf.push_back(8'h00);
		send_frame(ilac_pkg::LOAD_2W);
		lit_buf.push_back(8'hFF);
		send_frame(ilac_pkg::LOAD_4W);
		send_text("0x18", ilac_pkg::LOAD_2W);
		send_text("0x18", ilac_pkg::LOAD_3W);
		send_text("0x18", ilac_pkg::LOAD_4W);
		send_text("0x18", LOAD_NONE);
	endtask

	// Bulk random literals; switch idling on and off in stretches
	task automatic test_random_literals(input int target_words);
		int next_switch;
		next_switch = sent_words;
		while (sent_words < target_words) begin
			if (sent_words >= next_switch) begin
				idle_on     = ($urandom_range(0, 3) != 0);
				next_switch = sent_words + 150;
			end
			send_random_literal();
		end
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering
	task automatic test_output_stall();
		int i;
		idle_on = 1'b0;
		hold_req <= hold_req + 1;
		for (i = 0; i < 30; i++)
			send_random_literal();
		idle_on = 1'b1;
	endtask

	// Pause the sender until every result is back, then resume
	task automatic test_drain_pause();
		int i;
		for (i = 0; i < 10; i++)
			send_random_literal();
		wait_for_drain();
		for (i = 0; i < 10; i++)
			send_random_literal();
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_no_idle_tail(input int n_words);
		int stop_at;
		idle_on = 1'b0;
		stop_at = sent_words + n_words;
		while (sent_words < stop_at)
			send_random_literal();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'd0;
		s_tlast  <= 1'b0;
		s_tuser  <= 2'd0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sign_and_prefix();
		test_zero_forms();
		test_fraction_and_suffix();
		test_extremes_and_loads();
		test_random_literals(850);
		test_output_stall();
		test_drain_pause();
		test_no_idle_tail(150);

		// Drain the results, then let the pipeline settle
		wait_for_drain();
		repeat (8)
			@(posedge clk);
		if (expected_results.size() != 0) begin
			if (mismatch_count < MAX_REPORTS)
				$display("%0d expected results never arrived", expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("integer_literal_alignment_check_tb: PASS");
		else
			$display("integer_literal_alignment_check_tb: FAIL");
		$finish;
	end

	// Watchdog: stop a hung run
	initial begin
		#2000000;
		$display("integer_literal_alignment_check_tb: FAIL");
		$finish;
	end

endmodule
